// ===== src/radio_afc_step_tracker_assert.svh =====
// Assertion macros shared by the AFC step tracker RTL.
`ifndef RADIO_AFC_STEP_TRACKER_ASSERT_SVH
`define RADIO_AFC_STEP_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define AFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define AFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AFC_ASSERT(lbl, prop, msg)
`define AFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/afc_trk_pkg.sv =====
// Constants and types of the AFC step tracker.
`default_nettype none
package afc_trk_pkg;

    localparam int FREQ_W    = 24;
    localparam int CORR_W    = 12;
    localparam int LIM_W     = 11;
    localparam int NIB_W     = 4;
    localparam int PPM_W     = 8;
    localparam int SCALE_W   = 20;
    localparam int NUM_W     = LIM_W + SCALE_W;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [SCALE_W-1:0] PPM_SCALE     = SCALE_W'(950000);
    localparam logic [LIM_W-1:0]   AFC_LIMIT_RST = LIM_W'(1638);

    localparam logic       REQ_SET  = 1'b0;
    localparam logic       REQ_AFC  = 1'b1;
    localparam int         NIB_SIGN = NIB_W - 1;
    localparam logic [2:0] MAG_ONES = 3'b111;
    localparam logic [2:0] MAG_ZERO = 3'b000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// ===== src/afc_trk_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
`include "radio_afc_step_tracker_assert.svh"
module afc_trk_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [afc_trk_pkg::NUM_W-1:0]  num,
    input  wire logic [afc_trk_pkg::FREQ_W-1:0] den,
    output logic      [afc_trk_pkg::NUM_W-1:0]  quo,
    output afc_trk_pkg::div_stat_t              stat
);
    import afc_trk_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FREQ_W-1:0]   rem_reg;
    logic [NUM_W-1:0]    quo_reg;

    logic [FREQ_W:0]     trial;
    logic [FREQ_W+1:0]   diff;
    logic                ge;
    logic [FREQ_W-1:0]   rem_next;
    logic [NUM_W-1:0]    quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, den};
        ge       = ~diff[FREQ_W+1];
        rem_next = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `AFC_ASSERT(a_start_idle, start |-> !busy_reg, "divider started while busy")
    `AFC_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without a run")

endmodule
`default_nettype wire

// ===== src/radio_afc_step_tracker.sv =====
// Top level of the AFC step tracker: correction state, ppm sequencer, output register.
//
//   port group   direction   transfer when
//   s_*          in          s_valid & s_ready   (one request item)
//   m_*          out         m_valid & m_ready   (one result item)
//   cfg_*        in          cfg_valid & cfg_ready (afc_limit write)
//
// A set item, and an AFC item while no frequency is stored, finish in the accept cycle.
// An AFC update runs S_MUL (multiply, divider start), S_DIV (serial divider), then S_FIN (output load).
// The divider loop produces one quotient bit per cycle.
// s_ready is low while an update runs, or while a held result is not taken.
// Reset is synchronous, active low; it clears the frequency and correction, afc_limit goes to 1638.
`default_nettype none
`include "radio_afc_step_tracker_assert.svh"
module radio_afc_step_tracker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_req_type,
    input  wire logic [afc_trk_pkg::FREQ_W-1:0]  s_rf_freq,
    input  wire logic [afc_trk_pkg::NIB_W-1:0]   s_fei_nibble,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_freq_valid,
    output logic      [afc_trk_pkg::FREQ_W-1:0]  m_freq_word,
    output logic                                 m_ppm_valid,
    output logic signed [afc_trk_pkg::PPM_W-1:0] m_ppm_value,
    output logic signed [afc_trk_pkg::CORR_W-1:0] m_correction_now,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [afc_trk_pkg::LIM_W-1:0]   cfg_data
);
    import afc_trk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t                     state_reg;
    logic [LIM_W-1:0]           lim_reg;
    logic [FREQ_W-1:0]          nominal_reg;
    logic signed [CORR_W-1:0]   corr_reg;
    logic                       neg_reg;

    logic                       m_valid_reg;
    logic                       m_freq_valid_reg;
    logic [FREQ_W-1:0]          m_freq_word_reg;
    logic                       m_ppm_valid_reg;
    logic signed [PPM_W-1:0]    m_ppm_value_reg;
    logic signed [CORR_W-1:0]   m_corr_reg;

    logic                       out_free;
    logic                       in_xfer;
    logic                       afc_go;
    logic                       out_load;
    logic                       nib_neg;
    logic [2:0]                 nib_mag;
    logic signed [CORR_W:0]     corr_ext;
    logic signed [CORR_W:0]     step;
    logic signed [CORR_W:0]     sum;
    logic signed [CORR_W:0]     lim_pos;
    logic signed [CORR_W:0]     lim_neg;
    logic signed [CORR_W:0]     corr_clamped;
    logic signed [CORR_W-1:0]   corr_next;
    logic [FREQ_W-1:0]          freq_set;

    logic [CORR_W-1:0]          corr_abs;
    logic [LIM_W-1:0]           corr_mag;
    logic [NUM_W-1:0]           prod;
    logic                       div_start;
    logic [NUM_W-1:0]           quo;
    div_stat_t                  div_stat;
    logic signed [PPM_W-1:0]    ppm_sat;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign in_xfer   = s_valid && s_ready;
    assign afc_go    = in_xfer && (s_req_type == REQ_AFC) && (nominal_reg != '0);
    assign out_load  = (in_xfer && !afc_go) || ((state_reg == S_FIN) && out_free);
    assign cfg_ready = 1'b1;

    always_comb begin
        nib_neg  = s_fei_nibble[NIB_SIGN];
        nib_mag  = s_fei_nibble[2:0];
        corr_ext = {corr_reg[CORR_W-1], corr_reg};
        lim_pos  = {2'b00, lim_reg};
        lim_neg  = -lim_pos;
        if (nib_neg) begin
            step = (nib_mag == MAG_ONES) ? (CORR_W+1)'(1) : (CORR_W+1)'(4);
            sum  = corr_ext - step;
            corr_clamped = (sum < lim_neg) ? lim_neg : sum;
        end else begin
            step = (nib_mag == MAG_ZERO) ? (CORR_W+1)'(1) : (CORR_W+1)'(4);
            sum  = corr_ext + step;
            corr_clamped = (sum > lim_pos) ? lim_pos : sum;
        end
        corr_next = corr_clamped[CORR_W-1:0];
        freq_set  = s_rf_freq - {{(FREQ_W-CORR_W){corr_reg[CORR_W-1]}}, corr_reg};
    end

    always_comb begin
        corr_abs  = corr_reg[CORR_W-1] ? -corr_reg : corr_reg;
        corr_mag  = corr_abs[LIM_W-1:0];
        prod      = NUM_W'(corr_mag) * NUM_W'(PPM_SCALE);
        div_start = (state_reg == S_MUL);
    end

    afc_trk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod),
        .den     (nominal_reg),
        .quo     (quo),
        .stat    (div_stat)
    );

    always_comb begin
        if (neg_reg) begin
            if (quo > NUM_W'(128)) begin
                ppm_sat = {1'b1, {(PPM_W-1){1'b0}}};
            end else begin
                ppm_sat = -quo[PPM_W-1:0];
            end
        end else begin
            if (quo > NUM_W'(127)) begin
                ppm_sat = {1'b0, {(PPM_W-1){1'b1}}};
            end else begin
                ppm_sat = quo[PPM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lim_reg     <= AFC_LIMIT_RST;
            nominal_reg <= '0;
            corr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                lim_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (s_req_type == REQ_SET) begin
                            nominal_reg      <= s_rf_freq;
                            m_freq_valid_reg <= 1'b1;
                            m_freq_word_reg  <= freq_set;
                            m_ppm_valid_reg  <= 1'b0;
                            m_ppm_value_reg  <= '0;
                            m_corr_reg       <= corr_reg;
                        end else if (nominal_reg == '0) begin
                            m_freq_valid_reg <= 1'b0;
                            m_freq_word_reg  <= '0;
                            m_ppm_valid_reg  <= 1'b0;
                            m_ppm_value_reg  <= '0;
                            m_corr_reg       <= corr_reg;
                        end else begin
                            corr_reg  <= corr_next;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    neg_reg   <= corr_reg[CORR_W-1];
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_freq_valid_reg <= 1'b0;
                        m_freq_word_reg  <= '0;
                        m_ppm_valid_reg  <= 1'b1;
                        m_ppm_value_reg  <= ppm_sat;
                        m_corr_reg       <= corr_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_freq_valid     = m_freq_valid_reg;
    assign m_freq_word      = m_freq_word_reg;
    assign m_ppm_valid      = m_ppm_valid_reg;
    assign m_ppm_value      = m_ppm_value_reg;
    assign m_correction_now = m_corr_reg;

    `AFC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && state_reg == S_IDLE, "reset state")
    `AFC_ASSERT(a_corr_range, corr_reg != {1'b1, {(CORR_W-1){1'b0}}}, "correction out of range")
    `AFC_ASSERT(a_afc_starts, afc_go |=> (state_reg == S_MUL), "AFC update not started")
    `AFC_ASSERT(a_one_kind, m_valid |-> !(m_freq_valid && m_ppm_valid), "result flags both set")
    `AFC_ASSERT(a_div_run, state_reg == S_DIV |-> div_stat.busy || div_stat.done, "divider idle")

endmodule
`default_nettype wire
